// File: rtl/core/fsp_pkg.sv
// Package for the format specification parser: parser state, result word,
// character codes and the digit accumulate function.
// No dependencies; used by fsp_step and format_spec_parser_core.
package fsp_pkg;

	localparam int VALUE_BITS = 16;
	localparam int FIELD_W    = 16;
	localparam int ACC_EXT_W  = VALUE_BITS + 4;
	localparam logic [VALUE_BITS-1:0] NUM_MAX = {VALUE_BITS{1'b1}};

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_DOT   = 8'h2E;

	localparam int FLAG_ALT   = 0;
	localparam int FLAG_LEFT  = 1;
	localparam int FLAG_PLUS  = 2;
	localparam int FLAG_SPACE = 3;
	localparam int FLAG_ZERO  = 4;
	localparam int FLAG_N     = 5;

	typedef enum logic [1:0] {
		PH_EARLY = 2'd0,
		PH_WIDTH = 2'd1,
		PH_PREC  = 2'd2,
		PH_LATE  = 2'd3
	} phase_t;

	typedef enum logic [3:0] {
		CONV_C   = 4'd0,
		CONV_S   = 4'd1,
		CONV_P   = 4'd2,
		CONV_D   = 4'd3,
		CONV_I   = 4'd4,
		CONV_U   = 4'd5,
		CONV_XL  = 4'd6,
		CONV_XU  = 4'd7,
		CONV_PCT = 4'd8
	} conv_t;

	typedef struct packed {
		phase_t                phase;
		logic [FLAG_N-1:0]     flag_bits;
		logic [VALUE_BITS-1:0] width_acc;
		logic                  width_seen;
		logic [VALUE_BITS-1:0] prec_acc;
		logic                  prec_seen;
	} state_t;

	localparam state_t STATE_RESET = '{
		phase:      PH_EARLY,
		flag_bits:  '0,
		width_acc:  '0,
		width_seen: 1'b0,
		prec_acc:   '0,
		prec_seen:  1'b0
	};

	typedef struct packed {
		conv_t              conversion;
		logic               alt_form;
		logic               left_align;
		logic               force_sign;
		logic               space_sign;
		logic               zero_pad;
		logic               width_given;
		logic [FIELD_W-1:0] field_width;
		logic               prec_given;
		logic [FIELD_W-1:0] precision;
		logic               error;
	} result_t;

	// Multiplies by ten with two shifts and an add, adds the digit, then saturates.
	function automatic logic [VALUE_BITS-1:0] acc_digit(
		input logic [VALUE_BITS-1:0] acc,
		input logic [3:0]            d
	);
		logic [ACC_EXT_W-1:0] sum;
		sum = (ACC_EXT_W'(acc) << 3) + (ACC_EXT_W'(acc) << 1) + ACC_EXT_W'(d);
		if (sum > ACC_EXT_W'(NUM_MAX)) begin
			return NUM_MAX;
		end
		return sum[VALUE_BITS-1:0];
	endfunction

endpackage

// File: rtl/core/format_spec_parser_core.sv
// Format specification parser: one character word in, at most one result word out.
// Result words are registered: the last character is held in ch_s1, then its result in res_q.
// Throughput: one character word per cycle; only a held result that is not taken stalls input.
// Reset (arst_n low, asynchronous) empties both stages and returns the parser to its start state.
// Depends on fsp_pkg and fsp_step.
module format_spec_parser_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    ch,
	input  logic                          begin_req,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [3:0]                    conversion,
	output logic                          alt_form,
	output logic                          left_align,
	output logic                          force_sign,
	output logic                          space_sign,
	output logic                          zero_pad,
	output logic                          width_given,
	output logic [fsp_pkg::FIELD_W-1:0]   field_width,
	output logic                          prec_given,
	output logic [fsp_pkg::FIELD_W-1:0]   precision,
	output logic                          error
);

	logic             v_s1;
	logic [7:0]       ch_s1;
	logic             begin_s1;
	fsp_pkg::state_t  state_q;
	fsp_pkg::state_t  nxt;
	logic             emit;
	fsp_pkg::result_t res;
	fsp_pkg::result_t res_q;
	logic             out_valid_q;
	logic             fire;

	fsp_step u_step (
		.cur       (state_q),
		.ch        (ch_s1),
		.begin_req (begin_s1),
		.nxt       (nxt),
		.emit      (emit),
		.res       (res)
	);

	assign fire     = v_s1 && (!emit || !out_valid_q || out_ready);
	assign in_ready = !v_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ch_s1    <= ch;
			begin_s1 <= begin_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fsp_pkg::STATE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				state_q <= nxt;
			end
			if (fire && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			res_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign conversion  = res_q.conversion;
	assign alt_form    = res_q.alt_form;
	assign left_align  = res_q.left_align;
	assign force_sign  = res_q.force_sign;
	assign space_sign  = res_q.space_sign;
	assign zero_pad    = res_q.zero_pad;
	assign width_given = res_q.width_given;
	assign field_width = res_q.field_width;
	assign prec_given  = res_q.prec_given;
	assign precision   = res_q.precision;
	assign error       = res_q.error;

`ifndef SYNTHESIS
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> conversion == 4'd0 && field_width == '0
			&& precision == '0 && !width_given && !prec_given)
		else $error("error word carries non-zero fields");

	a_flag_prio: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(space_sign && force_sign) && !(zero_pad && left_align))
		else $error("flag priority broken");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s1 && out_valid && !out_ready)
		else $error("input stalled without a blocked result");

	a_reset_after_word: assert property (@(posedge clk) disable iff (!arst_n)
		fire && emit |=> state_q == fsp_pkg::STATE_RESET)
		else $error("parser state not cleared after a result word");
`endif

endmodule

// File: rtl/core/fsp_step.sv
// Next-state and result logic for one character of the format parser.
// Depends on fsp_pkg.
module fsp_step (
	input  fsp_pkg::state_t  cur,
	input  logic [7:0]       ch,
	input  logic             begin_req,
	output fsp_pkg::state_t  nxt,
	output logic             emit,
	output fsp_pkg::result_t res
);

	fsp_pkg::state_t  s;
	fsp_pkg::conv_t   conv;
	logic             conv_ok;
	logic             flag_ok;
	logic [2:0]       flag_idx;
	logic             is_digit;
	logic [3:0]       dval;
	logic             fall;

	always_comb begin
		conv_ok = 1'b1;
		conv    = fsp_pkg::CONV_C;
		case (ch)
			8'h63:   conv = fsp_pkg::CONV_C;
			8'h73:   conv = fsp_pkg::CONV_S;
			8'h70:   conv = fsp_pkg::CONV_P;
			8'h64:   conv = fsp_pkg::CONV_D;
			8'h69:   conv = fsp_pkg::CONV_I;
			8'h75:   conv = fsp_pkg::CONV_U;
			8'h78:   conv = fsp_pkg::CONV_XL;
			8'h58:   conv = fsp_pkg::CONV_XU;
			8'h25:   conv = fsp_pkg::CONV_PCT;
			default: conv_ok = 1'b0;
		endcase
	end

	always_comb begin
		flag_ok  = 1'b1;
		flag_idx = 3'(fsp_pkg::FLAG_ALT);
		case (ch)
			fsp_pkg::CH_HASH:  flag_idx = 3'(fsp_pkg::FLAG_ALT);
			fsp_pkg::CH_MINUS: flag_idx = 3'(fsp_pkg::FLAG_LEFT);
			fsp_pkg::CH_PLUS:  flag_idx = 3'(fsp_pkg::FLAG_PLUS);
			fsp_pkg::CH_SPACE: flag_idx = 3'(fsp_pkg::FLAG_SPACE);
			fsp_pkg::CH_ZERO:  flag_idx = 3'(fsp_pkg::FLAG_ZERO);
			default:           flag_ok = 1'b0;
		endcase
	end

	assign is_digit = (ch >= fsp_pkg::CH_ZERO) && (ch <= fsp_pkg::CH_NINE);
	assign dval     = 4'(ch - fsp_pkg::CH_ZERO);

	always_comb begin
		s    = begin_req ? fsp_pkg::STATE_RESET : cur;
		nxt  = s;
		emit = 1'b0;
		res  = '0;
		fall = 1'b0;

		case (s.phase)
			fsp_pkg::PH_WIDTH: begin
				if (is_digit) begin
					nxt.width_acc = fsp_pkg::acc_digit(s.width_acc, dval);
				end else if (ch == fsp_pkg::CH_DOT) begin
					nxt.prec_seen = 1'b1;
					nxt.prec_acc  = '0;
					nxt.phase     = fsp_pkg::PH_PREC;
				end else begin
					nxt.phase = fsp_pkg::PH_LATE;
					fall      = 1'b1;
				end
			end
			fsp_pkg::PH_PREC: begin
				if (is_digit) begin
					nxt.prec_acc = fsp_pkg::acc_digit(s.prec_acc, dval);
				end else begin
					nxt.phase = fsp_pkg::PH_LATE;
					fall      = 1'b1;
				end
			end
			default: fall = 1'b1;
		endcase

		if (fall) begin
			if (conv_ok) begin
				emit             = 1'b1;
				res.conversion   = conv;
				res.alt_form     = s.flag_bits[fsp_pkg::FLAG_ALT];
				res.left_align   = s.flag_bits[fsp_pkg::FLAG_LEFT];
				res.force_sign   = s.flag_bits[fsp_pkg::FLAG_PLUS];
				res.space_sign   = s.flag_bits[fsp_pkg::FLAG_SPACE]
					& ~s.flag_bits[fsp_pkg::FLAG_PLUS];
				res.zero_pad     = s.flag_bits[fsp_pkg::FLAG_ZERO]
					& ~s.flag_bits[fsp_pkg::FLAG_LEFT];
				res.width_given  = s.width_seen;
				res.field_width  = fsp_pkg::FIELD_W'(s.width_acc);
				res.prec_given   = s.prec_seen;
				res.precision    = fsp_pkg::FIELD_W'(s.prec_acc);
				nxt              = fsp_pkg::STATE_RESET;
			end else if (ch == fsp_pkg::CH_NUL) begin
				emit      = 1'b1;
				res.error = 1'b1;
				nxt       = fsp_pkg::STATE_RESET;
			end else if (flag_ok) begin
				nxt.flag_bits[flag_idx] = 1'b1;
			end else if (s.phase == fsp_pkg::PH_EARLY) begin
				if (is_digit) begin
					nxt.width_seen = 1'b1;
					nxt.width_acc  = fsp_pkg::VALUE_BITS'(dval);
					nxt.phase      = fsp_pkg::PH_WIDTH;
				end else if (ch == fsp_pkg::CH_DOT) begin
					nxt.prec_seen = 1'b1;
					nxt.prec_acc  = '0;
					nxt.phase     = fsp_pkg::PH_PREC;
				end
			end
		end
	end

endmodule

// File: sim/format_spec_parser_core_tb.sv
`timescale 1ns / 1ps
// Testbench for format_spec_parser_core: streams character words through the parser with random
// gaps and output stalls and checks each result word against an in-bench parser model.
// Depends on fsp_pkg and the parser RTL.
module format_spec_parser_core_tb;

	localparam int unsigned RANDOM_CHARS = 1100;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned PRESSURE_AT  = 40;
	localparam int unsigned PRESSURE_LEN = 250;
	localparam int unsigned DRAIN_CYCLES = 8;

	typedef struct {
		logic [7:0]  c;
		logic        bgn;
		int unsigned gap;
	} char_item_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic [7:0]                   ch = fsp_pkg::CH_NUL;
	logic                         begin_req = 1'b0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic [3:0]                   conversion;
	logic                         alt_form;
	logic                         left_align;
	logic                         force_sign;
	logic                         space_sign;
	logic                         zero_pad;
	logic                         width_given;
	logic [fsp_pkg::FIELD_W-1:0]  field_width;
	logic                         prec_given;
	logic [fsp_pkg::FIELD_W-1:0]  precision;
	logic                         error;

	char_item_t                   char_stream[$];
	fsp_pkg::result_t             parsed_specs[$];
	char_item_t                   next_char;
	bit                           spec_lead;
	bit                           tx_calm;
	int unsigned                  tx_wait;
	int unsigned                  rx_hold;
	int unsigned                  rx_draw;
	int unsigned                  results_seen;
	int unsigned                  mismatch_cnt = 0;
	int unsigned                  cycle_cnt = 0;
	int unsigned                  directed_n;
	fsp_pkg::result_t             exp_spec;

	fsp_pkg::phase_t              ps_phase = fsp_pkg::PH_EARLY;
	logic [fsp_pkg::FLAG_N-1:0]   ps_flags = '0;
	logic [fsp_pkg::FIELD_W-1:0]  ps_width = '0;
	logic                         ps_width_seen = 1'b0;
	logic [fsp_pkg::FIELD_W-1:0]  ps_prec = '0;
	logic                         ps_prec_seen = 1'b0;

	format_spec_parser_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.ch          (ch),
		.begin_req   (begin_req),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.conversion  (conversion),
		.alt_form    (alt_form),
		.left_align  (left_align),
		.force_sign  (force_sign),
		.space_sign  (space_sign),
		.zero_pad    (zero_pad),
		.width_given (width_given),
		.field_width (field_width),
		.prec_given  (prec_given),
		.precision   (precision),
		.error       (error)
	);

	function automatic void clear_parse();
		ps_phase      = fsp_pkg::PH_EARLY;
		ps_flags      = '0;
		ps_width      = '0;
		ps_width_seen = 1'b0;
		ps_prec       = '0;
		ps_prec_seen  = 1'b0;
	endfunction

	function automatic logic [fsp_pkg::FIELD_W-1:0] times_ten_plus(
			input logic [fsp_pkg::FIELD_W-1:0] acc, input logic [7:0] c);
		int unsigned v;
		v = 32'(acc) * 10 + 32'(c - fsp_pkg::CH_ZERO);
		if (v > 32'(fsp_pkg::NUM_MAX)) begin
			return fsp_pkg::NUM_MAX;
		end
		return v[fsp_pkg::FIELD_W-1:0];
	endfunction

	function automatic bit conv_lookup(input logic [7:0] c, output fsp_pkg::conv_t code);
		bit hit;
		hit = 1'b1;
		code = fsp_pkg::CONV_C;
		case (c)
			"c": code = fsp_pkg::CONV_C;
			"s": code = fsp_pkg::CONV_S;
			"p": code = fsp_pkg::CONV_P;
			"d": code = fsp_pkg::CONV_D;
			"i": code = fsp_pkg::CONV_I;
			"u": code = fsp_pkg::CONV_U;
			"x": code = fsp_pkg::CONV_XL;
			"X": code = fsp_pkg::CONV_XU;
			"%": code = fsp_pkg::CONV_PCT;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	function automatic int flag_index(input logic [7:0] c);
		case (c)
			fsp_pkg::CH_HASH:  return fsp_pkg::FLAG_ALT;
			fsp_pkg::CH_MINUS: return fsp_pkg::FLAG_LEFT;
			fsp_pkg::CH_PLUS:  return fsp_pkg::FLAG_PLUS;
			fsp_pkg::CH_SPACE: return fsp_pkg::FLAG_SPACE;
			fsp_pkg::CH_ZERO:  return fsp_pkg::FLAG_ZERO;
			default:           return -1;
		endcase
	endfunction

	// Advances the parser model by one character word and queues any result word it yields.
	function automatic void parse_char(input logic [7:0] c, input logic bgn);
		bit               is_dig;
		fsp_pkg::conv_t   code;
		int               fidx;
		fsp_pkg::result_t r;
		is_dig = (c >= fsp_pkg::CH_ZERO) && (c <= fsp_pkg::CH_NINE);
		if (bgn) begin
			clear_parse();
		end
		if (ps_phase == fsp_pkg::PH_WIDTH) begin
			if (is_dig) begin
				ps_width = times_ten_plus(ps_width, c);
				return;
			end
			if (c == fsp_pkg::CH_DOT) begin
				ps_prec_seen = 1'b1;
				ps_prec = '0;
				ps_phase = fsp_pkg::PH_PREC;
				return;
			end
			ps_phase = fsp_pkg::PH_LATE;
		end else if (ps_phase == fsp_pkg::PH_PREC) begin
			if (is_dig) begin
				ps_prec = times_ten_plus(ps_prec, c);
				return;
			end
			ps_phase = fsp_pkg::PH_LATE;
		end
		if (conv_lookup(c, code)) begin
			r = '0;
			r.conversion  = code;
			r.alt_form    = ps_flags[fsp_pkg::FLAG_ALT];
			r.left_align  = ps_flags[fsp_pkg::FLAG_LEFT];
			r.force_sign  = ps_flags[fsp_pkg::FLAG_PLUS];
			r.space_sign  = ps_flags[fsp_pkg::FLAG_SPACE] & ~ps_flags[fsp_pkg::FLAG_PLUS];
			r.zero_pad    = ps_flags[fsp_pkg::FLAG_ZERO] & ~ps_flags[fsp_pkg::FLAG_LEFT];
			r.width_given = ps_width_seen;
			r.field_width = ps_width;
			r.prec_given  = ps_prec_seen;
			r.precision   = ps_prec;
			parsed_specs.push_back(r);
			clear_parse();
			return;
		end
		if (c == fsp_pkg::CH_NUL) begin
			r = '0;
			r.error = 1'b1;
			parsed_specs.push_back(r);
			clear_parse();
			return;
		end
		fidx = flag_index(c);
		if (fidx >= 0) begin
			ps_flags[fidx] = 1'b1;
			return;
		end
		if (ps_phase == fsp_pkg::PH_EARLY) begin
			if (is_dig) begin
				ps_width_seen = 1'b1;
				ps_width = fsp_pkg::FIELD_W'(c - fsp_pkg::CH_ZERO);
				ps_phase = fsp_pkg::PH_WIDTH;
			end else if (c == fsp_pkg::CH_DOT) begin
				ps_prec_seen = 1'b1;
				ps_prec = '0;
				ps_phase = fsp_pkg::PH_PREC;
			end
		end
	endfunction

	function automatic void add_char(input logic [7:0] c);
		char_item_t it;
		it.c = c;
		it.bgn = spec_lead;
		it.gap = tx_calm ? 0 : $urandom_range(0, 18);
		char_stream.push_back(it);
		spec_lead = 1'b0;
	endfunction

	function automatic void push_str(input string s);
		for (int i = 0; i < s.len(); i++) begin
			add_char(s[i]);
		end
	endfunction

	function automatic logic [7:0] rand_digit(input int unsigned lo);
		return fsp_pkg::CH_ZERO + 8'($urandom_range(lo, 9));
	endfunction

	function automatic logic [7:0] junk_char();
		return 8'($urandom_range(8'h21, 8'h7E));
	endfunction

	function automatic int unsigned digit_run();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 3);
	endfunction

	// Mostly well-formed specifications with random content, some truncated by a NUL,
	// and now and then a burst of arbitrary bytes.
	function automatic void gen_spec();
		string conv_letters;
		string flag_chars;
		string late_chars;
		conv_letters = "csdpiuxX%";
		flag_chars = "#-+ 0";
		late_chars = "#-+ 05.";
		spec_lead = ($urandom_range(0, 9) != 0);
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 6)) begin
				spec_lead = ($urandom_range(0, 3) == 0);
				add_char(8'($urandom_range(0, 255)));
			end
			return;
		end
		repeat ($urandom_range(0, 4)) begin
			add_char(($urandom_range(0, 4) != 0) ? flag_chars[$urandom_range(0, 4)] : junk_char());
		end
		if ($urandom_range(0, 9) < 6) begin
			add_char(rand_digit(1));
			repeat (digit_run()) add_char(rand_digit(0));
		end
		if ($urandom_range(0, 1) != 0) begin
			add_char(fsp_pkg::CH_DOT);
			repeat (digit_run()) add_char(rand_digit(0));
		end
		if ($urandom_range(0, 9) < 3) begin
			repeat ($urandom_range(1, 3)) begin
				add_char(($urandom_range(0, 5) != 0) ? late_chars[$urandom_range(0, 6)] :
					junk_char());
			end
		end
		if ($urandom_range(0, 99) < 8) begin
			add_char(fsp_pkg::CH_NUL);
		end else begin
			add_char(conv_letters[$urandom_range(0, 8)]);
		end
	endfunction

	task automatic cmp_field(input string name, input logic [15:0] e, input logic [15:0] a);
		if (e !== a) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, e, a);
			mismatch_cnt++;
		end
	endtask

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			ch        <= fsp_pkg::CH_NUL;
			begin_req <= 1'b0;
			tx_wait   <= 0;
		end else begin
			if (in_valid && in_ready) begin
				parse_char(ch, begin_req);
			end
			if (!in_valid || in_ready) begin
				if (tx_wait != 0) begin
					tx_wait  <= tx_wait - 1;
					in_valid <= 1'b0;
				end else if (char_stream.size() != 0) begin
					next_char = char_stream.pop_front();
					ch        <= next_char.c;
					begin_req <= next_char.bgn;
					in_valid  <= 1'b1;
					tx_wait   <= (char_stream.size() != 0) ? char_stream[0].gap : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready    <= 1'b0;
			rx_hold      <= 0;
			results_seen <= 0;
		end else if (out_valid && out_ready) begin
			if (parsed_specs.size() == 0) begin
				$display("%0t: result word with nothing expected, expected none, got conv %0d err %0d",
					$time, conversion, error);
				mismatch_cnt++;
			end else begin
				exp_spec = parsed_specs.pop_front();
				cmp_field("conversion", 16'(exp_spec.conversion), 16'(conversion));
				cmp_field("alt_form", 16'(exp_spec.alt_form), 16'(alt_form));
				cmp_field("left_align", 16'(exp_spec.left_align), 16'(left_align));
				cmp_field("force_sign", 16'(exp_spec.force_sign), 16'(force_sign));
				cmp_field("space_sign", 16'(exp_spec.space_sign), 16'(space_sign));
				cmp_field("zero_pad", 16'(exp_spec.zero_pad), 16'(zero_pad));
				cmp_field("width_given", 16'(exp_spec.width_given), 16'(width_given));
				cmp_field("field_width", exp_spec.field_width, field_width);
				cmp_field("prec_given", 16'(exp_spec.prec_given), 16'(prec_given));
				cmp_field("precision", exp_spec.precision, precision);
				cmp_field("error", 16'(exp_spec.error), 16'(error));
			end
			results_seen <= results_seen + 1;
			// One long hold-off lets the parser fill up and push back on its input; other hold-offs are zero or random.
			if (results_seen == PRESSURE_AT) begin
				rx_draw = PRESSURE_LEN;
			end else if (cycle_cnt[10:9] == 2'd0) begin
				rx_draw = 0;
			end else begin
				rx_draw = $urandom_range(0, 18);
			end
			rx_hold   <= rx_draw;
			out_ready <= (rx_draw == 0);
		end else if (rx_hold != 0) begin
			rx_hold   <= rx_hold - 1;
			out_ready <= (rx_hold == 1);
		end else begin
			out_ready <= 1'b1;
		end
	end

	initial begin
		tx_calm = 1'b0;
		spec_lead = 1'b1;
		push_str("#-+ 0c");
		spec_lead = 1'b1;
		push_str("007.d");
		spec_lead = 1'b1;
		push_str("70000p");
		spec_lead = 1'b1;
		push_str("5");
		add_char(fsp_pkg::CH_NUL);
		push_str("%");
		spec_lead = 1'b1;
		push_str("3q0-s");
		spec_lead = 1'b1;
		push_str("i");
		spec_lead = 1'b1;
		push_str("u");
		spec_lead = 1'b1;
		push_str("x");
		spec_lead = 1'b1;
		push_str("X");
		directed_n = char_stream.size();
		while (char_stream.size() < directed_n + RANDOM_CHARS) begin
			tx_calm = ((char_stream.size() / 150) % 3 == 2);
			gen_spec();
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do @(negedge clk); while (char_stream.size() != 0 || in_valid || parsed_specs.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
